@@ hdl/serial_payload_receiver_defines.svh @@
// ----------------------------------------------------------------------------
// Serial payload receiver assertion macros
// Shared property macros for the checker of the serial payload receiver.
// ----------------------------------------------------------------------------
`ifndef SERIAL_PAYLOAD_RECEIVER_DEFINES_SVH
`define SERIAL_PAYLOAD_RECEIVER_DEFINES_SVH

// Same-cycle implication, sampled on clk and muted during reset.
`define SPR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and muted during reset.
`define SPR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/spr_pkg.sv @@
// ----------------------------------------------------------------------------
// spr_pkg
// Types, codes and reset values shared by the serial payload receiver.
// ----------------------------------------------------------------------------
package spr_pkg;

  // Default number of payload bytes between interim ACKs.
  localparam int ACK_INTERVAL_DEF = 64;

  // Input opcodes.
  localparam logic [1:0] OP_BYTE  = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;

  // Session phases.
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_HUNT = 3'd1;
  localparam logic [2:0] PH_RECV = 3'd2;
  localparam logic [2:0] PH_EOT  = 3'd3;
  localparam logic [2:0] PH_DONE = 3'd4;
  localparam logic [2:0] PH_FAIL = 3'd5;

  // Transmit codes.
  localparam logic [1:0] TX_NONE = 2'd0;
  localparam logic [1:0] TX_ACK  = 2'd1;
  localparam logic [1:0] TX_NAK  = 2'd2;

  // Failure causes.
  localparam logic [1:0] FC_NONE     = 2'd0;
  localparam logic [1:0] FC_PREAMBLE = 2'd1;
  localparam logic [1:0] FC_BAD_SIZE = 2'd2;
  localparam logic [1:0] FC_IDLE     = 2'd3;

  // Framing bytes.
  localparam logic [7:0] BYTE_PRE0 = 8'h5A;
  localparam logic [7:0] BYTE_PRE1 = 8'hA5;
  localparam logic [7:0] BYTE_EOT  = 8'h04;

  // Configuration register indexes.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SIZE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRE_TMO   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TMO  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EOT_WAIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_PER  = 3'd4;

  // Configuration reset values.
  localparam logic [23:0] RST_MAX_SIZE = 24'd500000;
  localparam logic [23:0] RST_PRE_TMO  = 24'd10000;
  localparam logic [23:0] RST_IDLE_TMO = 24'd5000;
  localparam logic [23:0] RST_EOT_WAIT = 24'd1000;
  localparam logic [15:0] RST_SYNC_PER = 16'd500;

  typedef struct packed {
    logic [23:0] max_payload_size;
    logic [23:0] preamble_timeout_ticks;
    logic [23:0] data_idle_timeout_ticks;
    logic [23:0] eot_wait_ticks;
    logic [15:0] sync_period_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  tx_code;
    logic        sync_request;
    logic        write_valid;
    logic [23:0] write_address;
    logic [7:0]  write_data;
    logic [2:0]  phase;
    logic [1:0]  fail_cause;
    logic [23:0] payload_size;
  } out_item_t;

endpackage

@@ hdl/spr_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// spr_cfg_regs
// Configuration register file written through a plain indexed write port.
// ----------------------------------------------------------------------------
module spr_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [spr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [spr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output spr_pkg::cfg_t                   cfg
);

  spr_pkg::cfg_t cfg_r;
  spr_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        spr_pkg::CFG_MAX_SIZE: cfg_nxt.max_payload_size        = cfg_wdata;
        spr_pkg::CFG_PRE_TMO:  cfg_nxt.preamble_timeout_ticks  = cfg_wdata;
        spr_pkg::CFG_IDLE_TMO: cfg_nxt.data_idle_timeout_ticks = cfg_wdata;
        spr_pkg::CFG_EOT_WAIT: cfg_nxt.eot_wait_ticks          = cfg_wdata;
        spr_pkg::CFG_SYNC_PER: cfg_nxt.sync_period_ticks       = cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_payload_size        <= spr_pkg::RST_MAX_SIZE;
      cfg_r.preamble_timeout_ticks  <= spr_pkg::RST_PRE_TMO;
      cfg_r.data_idle_timeout_ticks <= spr_pkg::RST_IDLE_TMO;
      cfg_r.eot_wait_ticks          <= spr_pkg::RST_EOT_WAIT;
      cfg_r.sync_period_ticks       <= spr_pkg::RST_SYNC_PER;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ hdl/spr_session.sv @@
// ----------------------------------------------------------------------------
// spr_session
// Session state and the single-pass step logic that turns one item into one result.
// ----------------------------------------------------------------------------
module spr_session #(
  parameter int ACK_INTERVAL = spr_pkg::ACK_INTERVAL_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_en,
  input  spr_pkg::in_item_t  item,
  input  spr_pkg::cfg_t      cfg,
  output spr_pkg::out_item_t result
);

  localparam int AW = $clog2(ACK_INTERVAL + 1);

  logic [2:0]    phase_r,       phase_nxt;
  logic [2:0]    hdr_step_r,    hdr_step_nxt;
  logic [31:0]   size_shift_r,  size_shift_nxt;
  logic [23:0]   rcv_cnt_r,     rcv_cnt_nxt;
  logic [AW-1:0] ack_acc_r,     ack_acc_nxt;
  logic [23:0]   phase_ticks_r, phase_ticks_nxt;
  logic [15:0]   sync_ticks_r,  sync_ticks_nxt;
  logic [1:0]    fail_code_r,   fail_code_nxt;
  logic [23:0]   acc_size_r,    acc_size_nxt;

  logic [24:0]   ticks_inc;
  logic [16:0]   sync_inc;
  logic [31:0]   size_new;
  logic [23:0]   rcv_inc;
  logic [AW-1:0] ack_inc;
  logic          last_byte;

  assign ticks_inc = {1'b0, phase_ticks_r} + 25'd1;
  assign sync_inc  = {1'b0, sync_ticks_r} + 17'd1;
  assign size_new  = {item.rx_byte, size_shift_r[31:8]};
  assign rcv_inc   = rcv_cnt_r + 24'd1;
  assign ack_inc   = ack_acc_r + AW'(1);
  assign last_byte = (rcv_inc == acc_size_r);

  always_comb begin
    phase_nxt       = phase_r;
    hdr_step_nxt    = hdr_step_r;
    size_shift_nxt  = size_shift_r;
    rcv_cnt_nxt     = rcv_cnt_r;
    ack_acc_nxt     = ack_acc_r;
    phase_ticks_nxt = phase_ticks_r;
    sync_ticks_nxt  = sync_ticks_r;
    fail_code_nxt   = fail_code_r;
    acc_size_nxt    = acc_size_r;
    result          = '0;

    if (item.opcode == spr_pkg::OP_START) begin
      hdr_step_nxt    = '0;
      size_shift_nxt  = '0;
      rcv_cnt_nxt     = '0;
      ack_acc_nxt     = '0;
      phase_ticks_nxt = '0;
      sync_ticks_nxt  = '0;
      fail_code_nxt   = spr_pkg::FC_NONE;
      acc_size_nxt    = '0;
      if (cfg.preamble_timeout_ticks == 24'd0) begin
        phase_nxt     = spr_pkg::PH_FAIL;
        fail_code_nxt = spr_pkg::FC_PREAMBLE;
      end else begin
        phase_nxt           = spr_pkg::PH_HUNT;
        result.sync_request = 1'b1;
      end
    end else if (item.opcode == spr_pkg::OP_TICK) begin
      unique case (phase_r)
        spr_pkg::PH_HUNT: begin
          if (ticks_inc >= {1'b0, cfg.preamble_timeout_ticks}) begin
            phase_nxt     = spr_pkg::PH_FAIL;
            fail_code_nxt = spr_pkg::FC_PREAMBLE;
          end else begin
            phase_ticks_nxt = ticks_inc[23:0];
            if (sync_inc > {1'b0, cfg.sync_period_ticks}) begin
              result.sync_request = 1'b1;
              sync_ticks_nxt      = '0;
            end else begin
              sync_ticks_nxt = sync_inc[15:0];
            end
          end
        end
        spr_pkg::PH_RECV: begin
          if (ticks_inc > {1'b0, cfg.data_idle_timeout_ticks}) begin
            phase_nxt     = spr_pkg::PH_FAIL;
            fail_code_nxt = spr_pkg::FC_IDLE;
          end else begin
            phase_ticks_nxt = ticks_inc[23:0];
          end
        end
        spr_pkg::PH_EOT: begin
          if (ticks_inc >= {1'b0, cfg.eot_wait_ticks}) begin
            phase_nxt = spr_pkg::PH_DONE;
          end else begin
            phase_ticks_nxt = ticks_inc[23:0];
          end
        end
        default: ;
      endcase
    end else if (item.opcode == spr_pkg::OP_BYTE) begin
      unique case (phase_r)
        spr_pkg::PH_HUNT: begin
          case (hdr_step_r)
            3'd0: begin
              if (item.rx_byte == spr_pkg::BYTE_PRE0) begin
                hdr_step_nxt = 3'd1;
              end
            end
            3'd1: begin
              if (item.rx_byte == spr_pkg::BYTE_PRE1) begin
                hdr_step_nxt = 3'd2;
              end else if (item.rx_byte == spr_pkg::BYTE_PRE0) begin
                hdr_step_nxt = 3'd1;
              end else begin
                hdr_step_nxt = 3'd0;
              end
            end
            default: begin
              // Size bytes arrive least significant first.
              size_shift_nxt = size_new;
              if (hdr_step_r >= 3'd5) begin
                hdr_step_nxt = 3'd0;
                if (size_new == 32'd0 || size_new > {8'd0, cfg.max_payload_size}) begin
                  result.tx_code = spr_pkg::TX_NAK;
                  phase_nxt      = spr_pkg::PH_FAIL;
                  fail_code_nxt  = spr_pkg::FC_BAD_SIZE;
                end else begin
                  result.tx_code  = spr_pkg::TX_ACK;
                  acc_size_nxt    = size_new[23:0];
                  rcv_cnt_nxt     = '0;
                  ack_acc_nxt     = '0;
                  phase_ticks_nxt = '0;
                  phase_nxt       = spr_pkg::PH_RECV;
                end
              end else begin
                hdr_step_nxt = hdr_step_r + 3'd1;
              end
            end
          endcase
        end
        spr_pkg::PH_RECV: begin
          result.write_valid   = 1'b1;
          result.write_address = rcv_cnt_r;
          result.write_data    = item.rx_byte;
          rcv_cnt_nxt          = rcv_inc;
          ack_acc_nxt          = ack_inc;
          phase_ticks_nxt      = '0;
          if (ack_inc >= AW'(ACK_INTERVAL) || last_byte) begin
            result.tx_code = spr_pkg::TX_ACK;
            ack_acc_nxt    = '0;
          end
          if (last_byte) begin
            phase_nxt = (cfg.eot_wait_ticks == 24'd0) ? spr_pkg::PH_DONE : spr_pkg::PH_EOT;
          end
        end
        spr_pkg::PH_EOT: begin
          if (item.rx_byte == spr_pkg::BYTE_EOT) begin
            phase_nxt = spr_pkg::PH_DONE;
          end
        end
        default: ;
      endcase
    end

    result.phase        = phase_nxt;
    result.fail_cause   = fail_code_nxt;
    result.payload_size = acc_size_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= spr_pkg::PH_IDLE;
      hdr_step_r    <= '0;
      size_shift_r  <= '0;
      rcv_cnt_r     <= '0;
      ack_acc_r     <= '0;
      phase_ticks_r <= '0;
      sync_ticks_r  <= '0;
      fail_code_r   <= spr_pkg::FC_NONE;
      acc_size_r    <= '0;
    end else if (step_en) begin
      phase_r       <= phase_nxt;
      hdr_step_r    <= hdr_step_nxt;
      size_shift_r  <= size_shift_nxt;
      rcv_cnt_r     <= rcv_cnt_nxt;
      ack_acc_r     <= ack_acc_nxt;
      phase_ticks_r <= phase_ticks_nxt;
      sync_ticks_r  <= sync_ticks_nxt;
      fail_code_r   <= fail_code_nxt;
      acc_size_r    <= acc_size_nxt;
    end
  end

endmodule

@@ hdl/serial_payload_receiver.sv @@
// ----------------------------------------------------------------------------
// serial_payload_receiver
// Serial boot upload receiver: preamble and size hunt, payload write-out, ACK/NAK.
// ----------------------------------------------------------------------------
// Each input beat (a received byte, a millisecond tick or a start command)
// produces exactly one result beat. An item passes through an input register,
// one pass of step logic that also updates the session state, and a result
// register, so a result is presented once its beat has moved from the input
// register into the result register. A new beat can be accepted in every cycle
// while out_ready stays high. The result register lets the next beat be taken
// in the cycle the current result is handed off. While a result is held, the
// input register keeps at most one further beat, and in_ready is low for as
// long as both registers are full and out_ready is low. The sustained rate is
// one beat per cycle while out_ready stays high, set by the session state update.
// Configuration registers are written at once through cfg_we and must be
// changed only while no beat is in flight. There is no clearing pass after
// reset.
module serial_payload_receiver #(
  parameter int ACK_INTERVAL = spr_pkg::ACK_INTERVAL_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input channel.
  input  logic                            in_valid,
  output logic                            in_ready,
  input  spr_pkg::in_item_t               in_data,
  // Result channel.
  output logic                            out_valid,
  input  logic                            out_ready,
  output spr_pkg::out_item_t              out_data,
  // Configuration write port.
  input  logic                            cfg_we,
  input  logic [spr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [spr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  // Input register stage.
  logic               in_valid_r;
  spr_pkg::in_item_t  in_data_r;

  // Result register stage.
  logic               out_valid_r;
  spr_pkg::out_item_t out_data_r;

  spr_pkg::cfg_t      cfg;
  spr_pkg::out_item_t step_result;

  // The result register can load when it is empty or being drained now.
  logic out_load;
  // The held input beat moves through the step logic this cycle.
  logic step_en;

  assign out_load = !out_valid_r || out_ready;
  assign step_en  = in_valid_r && out_load;
  assign in_ready = !in_valid_r || step_en;

  spr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // The session state advances only when the step result is captured, so a
  // stalled beat is evaluated against unchanged state until it moves on.
  spr_session #(
    .ACK_INTERVAL (ACK_INTERVAL)
  ) u_session (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (in_data_r),
    .cfg     (cfg),
    .result  (step_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_data_r <= step_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ hdl/spr_checker.sv @@
// ----------------------------------------------------------------------------
// spr_checker
// Port-level checks of the serial payload receiver, bound to the top level.
// ----------------------------------------------------------------------------
`include "serial_payload_receiver_defines.svh"

module spr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input spr_pkg::out_item_t out_data
);

  // A stalled result must stay put until it is taken.
  `SPR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

  // A failure cause is reported exactly while the session is failed.
  `SPR_ASSERT_NOW(a_fail_cause, out_valid, (out_data.phase == spr_pkg::PH_FAIL) == (out_data.fail_cause != spr_pkg::FC_NONE), "failure cause does not match phase")

  // A NAK is only ever sent for a rejected size.
  `SPR_ASSERT_NOW(a_nak_cause, out_valid && out_data.tx_code == spr_pkg::TX_NAK, out_data.phase == spr_pkg::PH_FAIL && out_data.fail_cause == spr_pkg::FC_BAD_SIZE, "NAK without bad size failure")

  // Payload writes happen only while receiving or on the last byte.
  `SPR_ASSERT_NOW(a_write_phase, out_valid && out_data.write_valid, out_data.phase == spr_pkg::PH_RECV || out_data.phase == spr_pkg::PH_EOT || out_data.phase == spr_pkg::PH_DONE, "payload write outside receive")

  // Every write address lies inside the accepted payload.
  `SPR_ASSERT_NOW(a_write_range, out_valid && out_data.write_valid, out_data.write_address < out_data.payload_size, "write address beyond payload size")

endmodule

bind serial_payload_receiver spr_checker u_spr_checker (.*);

@@ bench/serial_payload_receiver_test.sv @@
// ----------------------------------------------------------------------------
// Serial payload receiver testbench
// Walks a short table of hand-picked beats through the upload receiver and
// then runs randomized upload sessions under freshly drawn settings. Every
// accepted beat is run through a local model of the session logic, and the
// result beats that come back are compared field by field, in order.
// ----------------------------------------------------------------------------
module serial_payload_receiver_test;
  timeunit 1ns;
  timeprecision 1ps;

  import spr_pkg::*;

  // The block ignores opcode 3; the package has no name for it.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int MAX_GAP       = 13;     // longest idle stretch drawn per beat
  localparam int HOLD_AT       = 200;    // result count at which the long hold starts
  localparam int HOLD_CYCLES   = 80;     // length of the long receiver hold
  localparam int SETTLE_CYCLES = 4;      // two-stage pipe plus margin
  localparam int WORK_TARGET   = 450;    // beats sent in all before the run winds down
  localparam int CYCLE_LIMIT   = 200000;
  localparam int PLAN_ROWS     = 23;

  localparam cfg_t HUNT_ZERO_CFG = '{RST_MAX_SIZE, 24'd0, RST_IDLE_TMO, RST_EOT_WAIT,
                                     RST_SYNC_PER};
  localparam cfg_t EXTREME_CFG   = '{24'hFFFFFF, 24'hFFFFFF, 24'd0, 24'd0, 16'd1};

  // Settings to load before a row of the directed table.
  typedef enum logic [1:0] {SET_KEEP, SET_HUNT_ZERO, SET_EXTREMES} preset_e;

  typedef struct packed {
    preset_e   preset;
    in_item_t  beat;
    logic      typed;     // the answer below is used instead of the model
    out_item_t want;
  } plan_row_t;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  serial_payload_receiver uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Local copy of the register file and of the session state. The register
  // copy is only ever changed while the block is drained, so it always matches
  // what the block sees for the beats in flight.
  cfg_t        settings;
  logic [2:0]  sess_phase;
  logic [2:0]  hdr_step;
  logic [31:0] size_acc;
  logic [23:0] rx_count;
  int          ack_count;
  logic [23:0] tick_count;
  logic [15:0] sync_count;
  logic [1:0]  cause;
  logic [23:0] size_ok;

  out_item_t   upload_answers[$];   // one answer per accepted beat, oldest first
  plan_row_t   plan [PLAN_ROWS];
  int          bad_fields = 0;
  int          work_items = 0;
  bit          quiet      = 1'b0;   // both sides run without idling while set

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Clears everything a start command clears; the phase is left alone.
  function automatic void drop_session();
    hdr_step   = 3'd0;
    size_acc   = 32'd0;
    rx_count   = 24'd0;
    ack_count  = 0;
    tick_count = 24'd0;
    sync_count = 16'd0;
    cause      = FC_NONE;
    size_ok    = 24'd0;
  endfunction

  // Advances the session by one beat and returns the result beat it causes.
  function automatic out_item_t upload_step(in_item_t beat);
    out_item_t   r;
    logic [24:0] next_ticks;
    logic [16:0] next_sync;
    r          = '0;
    next_ticks = {1'b0, tick_count} + 25'd1;
    next_sync  = {1'b0, sync_count} + 17'd1;
    case (beat.opcode)
      OP_START: begin
        drop_session();
        // With no hunt time at all the session is over before it starts.
        if (settings.preamble_timeout_ticks == 24'd0) begin
          sess_phase = PH_FAIL;
          cause      = FC_PREAMBLE;
        end else begin
          sess_phase     = PH_HUNT;
          r.sync_request = 1'b1;
        end
      end
      OP_TICK: begin
        if (sess_phase == PH_HUNT) begin
          if (next_ticks >= {1'b0, settings.preamble_timeout_ticks}) begin
            sess_phase = PH_FAIL;
            cause      = FC_PREAMBLE;
          end else begin
            tick_count = next_ticks[23:0];
            if (next_sync > {1'b0, settings.sync_period_ticks}) begin
              r.sync_request = 1'b1;
              sync_count     = 16'd0;
            end else begin
              sync_count = next_sync[15:0];
            end
          end
        end else if (sess_phase == PH_RECV) begin
          if (next_ticks > {1'b0, settings.data_idle_timeout_ticks}) begin
            sess_phase = PH_FAIL;
            cause      = FC_IDLE;
          end else begin
            tick_count = next_ticks[23:0];
          end
        end else if (sess_phase == PH_EOT) begin
          if (next_ticks >= {1'b0, settings.eot_wait_ticks}) sess_phase = PH_DONE;
          else tick_count = next_ticks[23:0];
        end
      end
      OP_BYTE: begin
        if (sess_phase == PH_HUNT) begin
          if (hdr_step == 3'd0) begin
            if (beat.rx_byte == BYTE_PRE0) hdr_step = 3'd1;
          end else if (hdr_step == 3'd1) begin
            // A repeated first preamble byte keeps the hunt one step in.
            if (beat.rx_byte == BYTE_PRE1) hdr_step = 3'd2;
            else if (beat.rx_byte == BYTE_PRE0) hdr_step = 3'd1;
            else hdr_step = 3'd0;
          end else begin
            // Size arrives least significant byte first.
            size_acc = {beat.rx_byte, size_acc[31:8]};
            hdr_step = hdr_step + 3'd1;
            if (hdr_step >= 3'd6) begin
              hdr_step = 3'd0;
              if (size_acc == 32'd0 || size_acc > {8'h00, settings.max_payload_size}) begin
                r.tx_code  = TX_NAK;
                sess_phase = PH_FAIL;
                cause      = FC_BAD_SIZE;
              end else begin
                r.tx_code  = TX_ACK;
                size_ok    = size_acc[23:0];
                rx_count   = 24'd0;
                ack_count  = 0;
                tick_count = 24'd0;
                sess_phase = PH_RECV;
              end
            end
          end
        end else if (sess_phase == PH_RECV) begin
          r.write_valid   = 1'b1;
          r.write_address = rx_count;
          r.write_data    = beat.rx_byte;
          rx_count        = rx_count + 24'd1;
          ack_count       = ack_count + 1;
          tick_count      = 24'd0;
          if (ack_count >= ACK_INTERVAL_DEF || rx_count == size_ok) begin
            r.tx_code = TX_ACK;
            ack_count = 0;
          end
          if (rx_count == size_ok) begin
            sess_phase = (settings.eot_wait_ticks == 24'd0) ? PH_DONE : PH_EOT;
          end
        end else if (sess_phase == PH_EOT) begin
          if (beat.rx_byte == BYTE_EOT) sess_phase = PH_DONE;
        end
      end
      default: ;
    endcase
    r.phase        = sess_phase;
    r.fail_cause   = cause;
    r.payload_size = size_ok;
    return r;
  endfunction

  function automatic out_item_t outcome(logic [1:0] tx, logic sync, logic wv,
                                        logic [23:0] addr, logic [7:0] data,
                                        logic [2:0] ph, logic [1:0] fc,
                                        logic [23:0] size);
    out_item_t r;
    r.tx_code       = tx;
    r.sync_request  = sync;
    r.write_valid   = wv;
    r.write_address = addr;
    r.write_data    = data;
    r.phase         = ph;
    r.fail_cause    = fc;
    r.payload_size  = size;
    return r;
  endfunction

  // Offers one beat and waits for the handshake. Entered and left at a falling
  // edge. Valid is only dropped when a gap is actually taken, so a beat that
  // follows right away never sees valid lowered and raised in the same step.
  task automatic send_beat(in_item_t beat, logic typed, out_item_t typed_answer);
    int        gap;
    out_item_t answer;
    gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // The beat is taken at this edge; update the model right here.
    work_items++;
    answer = upload_step(beat);
    upload_answers.push_back(typed ? typed_answer : answer);
    @(negedge clk);
  endtask

  task automatic offer(logic [1:0] op, logic [7:0] value);
    in_item_t beat;
    beat.opcode  = op;
    beat.rx_byte = value;
    send_beat(beat, 1'b0, '0);
  endtask

  // Lets every result in flight come back before the settings are touched.
  task automatic settle();
    in_valid <= 1'b0;
    while (upload_answers.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
  endtask

  task automatic load_config(cfg_t c);
    put_reg(CFG_MAX_SIZE, c.max_payload_size);
    put_reg(CFG_PRE_TMO,  c.preamble_timeout_ticks);
    put_reg(CFG_IDLE_TMO, c.data_idle_timeout_ticks);
    put_reg(CFG_EOT_WAIT, c.eot_wait_ticks);
    put_reg(CFG_SYNC_PER, {8'h00, c.sync_period_ticks});
    cfg_we   <= 1'b0;
    settings  = c;
  endtask

  task automatic match_field(string name, logic [23:0] want, logic [23:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      bad_fields++;
    end
  endtask

  // One upload session under freshly drawn settings. Most sessions are well
  // formed so the payload path is reached; small timeouts, odd sizes, stray
  // ticks and an occasional broken preamble push some of them into failure.
  task automatic run_session();
    cfg_t        c;
    logic [31:0] len;
    logic [23:0] cap;
    logic [7:0]  value;
    int          span;
    int          k;
    case ($urandom_range(0, 7))
      0:       c.max_payload_size = 24'd1;
      1:       c.max_payload_size = 24'hFFFFFF;
      default: c.max_payload_size = 24'($urandom_range(1, 130));
    endcase
    case ($urandom_range(0, 7))
      0:       c.preamble_timeout_ticks = 24'd0;
      1:       c.preamble_timeout_ticks = 24'hFFFFFF;
      default: c.preamble_timeout_ticks = 24'($urandom_range(4, 40));
    endcase
    case ($urandom_range(0, 5))
      0:       c.data_idle_timeout_ticks = 24'd0;
      1:       c.data_idle_timeout_ticks = 24'hFFFFFF;
      default: c.data_idle_timeout_ticks = 24'($urandom_range(1, 6));
    endcase
    case ($urandom_range(0, 5))
      0:       c.eot_wait_ticks = 24'd0;
      1:       c.eot_wait_ticks = 24'hFFFFFF;
      default: c.eot_wait_ticks = 24'($urandom_range(1, 6));
    endcase
    case ($urandom_range(0, 5))
      0:       c.sync_period_ticks = 16'd1;
      1:       c.sync_period_ticks = 16'hFFFF;
      default: c.sync_period_ticks = 16'($urandom_range(1, 8));
    endcase
    settle();
    load_config(c);
    quiet = ($urandom_range(0, 3) == 0);

    offer(OP_START, 8'($urandom));
    // Line noise and ticks while the preamble is being hunted.
    repeat ($urandom_range(0, 5)) begin
      case ($urandom_range(0, 3))
        0:       offer(OP_BYTE, 8'($urandom));
        1:       offer(OP_UNUSED, 8'($urandom));
        default: offer(OP_TICK, 8'($urandom));
      endcase
    end
    if ($urandom_range(0, 5) == 0) begin
      offer(OP_BYTE, BYTE_PRE0);
      offer(OP_BYTE, 8'($urandom));
    end
    offer(OP_BYTE, BYTE_PRE0);
    offer(OP_BYTE, BYTE_PRE1);

    case ($urandom_range(0, 9))
      0: len = 32'd0;
      1: begin
        if (c.max_payload_size == 24'hFFFFFF || $urandom_range(0, 1) == 1)
          len = {8'($urandom_range(1, 255)), 24'($urandom)};
        else
          len = {8'h00, c.max_payload_size} + 32'($urandom_range(1, 3));
      end
      default: begin
        cap = (c.max_payload_size > 24'd130) ? 24'd130 : c.max_payload_size;
        len = 32'($urandom_range(1, cap));
      end
    endcase
    for (k = 0; k < 4; k++) offer(OP_BYTE, len[8*k +: 8]);

    // After a NAK a few bytes are still sent; the block has to ignore them.
    if (len != 32'd0 && len <= {8'h00, c.max_payload_size}) span = int'(len);
    else span = $urandom_range(0, 3);
    for (k = 0; k < span; k++) begin
      if ($urandom_range(0, 11) == 0) begin
        repeat ($urandom_range(1, 3)) offer(OP_TICK, 8'($urandom));
      end
      if ($urandom_range(0, 199) == 0) offer(OP_START, 8'($urandom));
      value = 8'($urandom);
      if ($urandom_range(0, 19) == 0) value = BYTE_EOT;
      offer(OP_BYTE, value);
    end

    // Wait for end of transmission: stray bytes, ticks, then usually EOT.
    repeat ($urandom_range(0, 3)) offer(OP_BYTE, 8'($urandom));
    repeat ($urandom_range(0, 6)) offer(OP_TICK, 8'($urandom));
    if ($urandom_range(0, 3) != 0) offer(OP_BYTE, BYTE_EOT);
    if ($urandom_range(0, 3) == 0) offer(OP_UNUSED, 8'($urandom));
  endtask

  // Result side. Before each result it draws a stall, except once, when it
  // holds off for a long stretch so that the block fills and stops taking
  // beats while the sender keeps offering.
  initial begin : result_side
    int        stall;
    int        taken;
    out_item_t want;
    taken = 0;
    @(posedge rst_n);
    forever begin
      if (taken == HOLD_AT) stall = HOLD_CYCLES;
      else stall = quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
      if (upload_answers.size() == 0) begin
        $display("%0t: result beat with nothing outstanding, got %h", $time, out_data);
        bad_fields++;
      end else begin
        want = upload_answers.pop_front();
        match_field("tx_code", 24'(want.tx_code), 24'(out_data.tx_code));
        match_field("sync_request", 24'(want.sync_request), 24'(out_data.sync_request));
        match_field("write_valid", 24'(want.write_valid), 24'(out_data.write_valid));
        match_field("write_address", want.write_address, out_data.write_address);
        match_field("write_data", 24'(want.write_data), 24'(out_data.write_data));
        match_field("phase", 24'(want.phase), 24'(out_data.phase));
        match_field("fail_cause", 24'(want.fail_cause), 24'(out_data.fail_cause));
        match_field("payload_size", want.payload_size, out_data.payload_size);
      end
      @(negedge clk);
    end
  end

  // Cycle limit. The slowest legal run is far below it.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("** serial_payload_receiver: FAILED **");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int r;
    // Directed table. Rows with a typed answer are easy to read off by hand:
    // beats in idle, starts, NAK and ACK of the size, both payload bytes and
    // EOT. The rest go through the model.
    plan[0]  = '{SET_KEEP, '{OP_BYTE, BYTE_PRE0}, 1'b1,
                 outcome(TX_NONE, 1'b0, 1'b0, 24'd0, 8'h00, PH_IDLE, FC_NONE, 24'd0)};
    plan[1]  = '{SET_KEEP, '{OP_UNUSED, 8'hFF}, 1'b1,
                 outcome(TX_NONE, 1'b0, 1'b0, 24'd0, 8'h00, PH_IDLE, FC_NONE, 24'd0)};
    plan[2]  = '{SET_KEEP, '{OP_START, 8'h00}, 1'b1,
                 outcome(TX_NONE, 1'b1, 1'b0, 24'd0, 8'h00, PH_HUNT, FC_NONE, 24'd0)};
    // First preamble byte twice in a row, then the second one.
    plan[3]  = '{SET_KEEP, '{OP_BYTE, BYTE_PRE0}, 1'b0, '0};
    plan[4]  = '{SET_KEEP, '{OP_BYTE, BYTE_PRE0}, 1'b0, '0};
    plan[5]  = '{SET_KEEP, '{OP_BYTE, BYTE_PRE1}, 1'b0, '0};
    plan[6]  = '{SET_KEEP, '{OP_BYTE, 8'h02}, 1'b0, '0};
    plan[7]  = '{SET_KEEP, '{OP_BYTE, 8'h00}, 1'b0, '0};
    plan[8]  = '{SET_KEEP, '{OP_BYTE, 8'h00}, 1'b0, '0};
    plan[9]  = '{SET_KEEP, '{OP_BYTE, 8'h00}, 1'b1,
                 outcome(TX_ACK, 1'b0, 1'b0, 24'd0, 8'h00, PH_RECV, FC_NONE, 24'd2)};
    plan[10] = '{SET_KEEP, '{OP_BYTE, 8'hFF}, 1'b1,
                 outcome(TX_NONE, 1'b0, 1'b1, 24'd0, 8'hFF, PH_RECV, FC_NONE, 24'd2)};
    plan[11] = '{SET_KEEP, '{OP_BYTE, 8'h00}, 1'b1,
                 outcome(TX_ACK, 1'b0, 1'b1, 24'd1, 8'h00, PH_EOT, FC_NONE, 24'd2)};
    plan[12] = '{SET_KEEP, '{OP_BYTE, BYTE_EOT}, 1'b1,
                 outcome(TX_NONE, 1'b0, 1'b0, 24'd0, 8'h00, PH_DONE, FC_NONE, 24'd2)};
    // No hunt time: the start fails at once, without a sync request.
    plan[13] = '{SET_HUNT_ZERO, '{OP_START, 8'hFF}, 1'b1,
                 outcome(TX_NONE, 1'b0, 1'b0, 24'd0, 8'h00, PH_FAIL, FC_PREAMBLE, 24'd0)};
    // Extreme settings: sync period of one tick, then a zero size.
    plan[14] = '{SET_EXTREMES, '{OP_START, 8'h00}, 1'b1,
                 outcome(TX_NONE, 1'b1, 1'b0, 24'd0, 8'h00, PH_HUNT, FC_NONE, 24'd0)};
    plan[15] = '{SET_KEEP, '{OP_TICK, 8'h00}, 1'b0, '0};
    plan[16] = '{SET_KEEP, '{OP_TICK, 8'hFF}, 1'b0, '0};
    plan[17] = '{SET_KEEP, '{OP_BYTE, BYTE_PRE0}, 1'b0, '0};
    plan[18] = '{SET_KEEP, '{OP_BYTE, BYTE_PRE1}, 1'b0, '0};
    plan[19] = '{SET_KEEP, '{OP_BYTE, 8'h00}, 1'b0, '0};
    plan[20] = '{SET_KEEP, '{OP_BYTE, 8'h00}, 1'b0, '0};
    plan[21] = '{SET_KEEP, '{OP_BYTE, 8'h00}, 1'b0, '0};
    plan[22] = '{SET_KEEP, '{OP_BYTE, 8'h00}, 1'b1,
                 outcome(TX_NAK, 1'b0, 1'b0, 24'd0, 8'h00, PH_FAIL, FC_BAD_SIZE, 24'd0)};

    settings   = '{RST_MAX_SIZE, RST_PRE_TMO, RST_IDLE_TMO, RST_EOT_WAIT, RST_SYNC_PER};
    sess_phase = PH_IDLE;
    drop_session();

    // Synchronous reset, released on a falling edge.
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (r = 0; r < PLAN_ROWS; r++) begin
      if (plan[r].preset != SET_KEEP) begin
        settle();
        load_config(plan[r].preset == SET_HUNT_ZERO ? HUNT_ZERO_CFG : EXTREME_CFG);
      end
      send_beat(plan[r].beat, plan[r].typed, plan[r].want);
    end

    while (work_items < WORK_TARGET) run_session();

    settle();
    if (bad_fields == 0) begin
      $display("** serial_payload_receiver: PASSED **");
    end else begin
      $display("** serial_payload_receiver: FAILED **");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/spr_pkg.sv
hdl/spr_cfg_regs.sv
hdl/spr_session.sv
hdl/serial_payload_receiver.sv
hdl/spr_checker.sv
bench/serial_payload_receiver_test.sv
